// ===== design/eci_pkg.sv =====
// Shared types, codes and sizes of the edge counting input port.
package eci_pkg;

   // Number of input channels in use (1 to 8).
   localparam int CHANNELS = 8;
   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [7:0] CHAN_MASK = 8'((9'd1 << CHANNELS) - 9'd1);

   // Command codes.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_WRITE  = 2'd2;

   // Register map.
   localparam logic [5:0] ADDR_LEVELS     = 6'd0;
   localparam logic [5:0] ADDR_RISE       = 6'd1;
   localparam logic [5:0] ADDR_FALL       = 6'd2;
   localparam logic [5:0] ADDR_RESET      = 6'd3;
   localparam logic [5:0] ADDR_COUNT_BASE = 6'd4;

   // Status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_ADDR = 2'd1;
   localparam logic [1:0] STAT_BAD_CHAN = 2'd2;

   // Depth of the queue between the decoder and the execution unit.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_SAMPLE,
      OP_RD_LEVELS,
      OP_RD_RISE,
      OP_RD_FALL,
      OP_RD_COUNT,
      OP_WR_RISE,
      OP_WR_FALL,
      OP_CLEAR,
      OP_BAD_ADDR,
      OP_BAD_CHAN
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [7:0]            data;      // masked levels or masked write byte
      logic [CHAN_IDX_W-1:0] chan;      // counter index, zero based
      logic [1:0]            byte_sel;  // counter byte, little endian
   } op_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

endpackage

// ===== design/eci_front.sv =====
// Command decoder: accepts requests and classifies them into operations.
module eci_front
   import eci_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_input_levels,
   input  logic [5:0] req_register_address,
   input  logic [7:0] req_write_data,
   input  q_stat_type q_stat,
   output logic       push,
   output op_type     op
);

   logic [5:0] offset;
   logic [3:0] cnt_chan;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;
   assign offset    = req_register_address - ADDR_COUNT_BASE;
   assign cnt_chan  = offset[5:2];

   always_comb begin
      op.kind     = OP_BAD_ADDR;
      op.data     = 8'd0;
      op.chan     = '0;
      op.byte_sel = offset[1:0];
      unique case (req_command)
         CMD_SAMPLE: begin
            op.kind = OP_SAMPLE;
            op.data = req_input_levels & CHAN_MASK;
         end
         CMD_READ: begin
            if (req_register_address == ADDR_LEVELS) begin
               op.kind = OP_RD_LEVELS;
            end else if (req_register_address == ADDR_RISE) begin
               op.kind = OP_RD_RISE;
            end else if (req_register_address == ADDR_FALL) begin
               op.kind = OP_RD_FALL;
            end else if (req_register_address >= ADDR_COUNT_BASE &&
                         cnt_chan < 4'(CHANNELS)) begin
               op.kind = OP_RD_COUNT;
               op.chan = cnt_chan[CHAN_IDX_W-1:0];
            end
         end
         CMD_WRITE: begin
            op.data = req_write_data & CHAN_MASK;
            if (req_register_address == ADDR_RISE) begin
               op.kind = OP_WR_RISE;
            end else if (req_register_address == ADDR_FALL) begin
               op.kind = OP_WR_FALL;
            end else if (req_register_address == ADDR_RESET) begin
               if (req_write_data >= 8'd1 && req_write_data <= 8'(CHANNELS)) begin
                  op.kind = OP_CLEAR;
                  op.chan = CHAN_IDX_W'(req_write_data - 8'd1);
               end else begin
                  op.kind = OP_BAD_CHAN;
               end
            end
         end
         default: op.kind = OP_BAD_ADDR;
      endcase
   end

endmodule

// ===== design/eci_queue.sv =====
// Short first-in first-out queue of decoded operations.
module eci_queue
   import eci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  op_type     push_op,
   input  logic       pop,
   output logic       q_valid,
   output op_type     q_op,
   output q_stat_type q_stat
);

   op_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid      = count_ff != '0;
   assign q_op         = slot_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== design/eci_back.sv =====
// Execution unit: holds levels, masks and edge counters, and the result register.
module eci_back
   import eci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  op_type     q_op,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_status
);

   logic [7:0]  levels_ff, levels_in;
   logic [7:0]  rise_ff, rise_in;
   logic [7:0]  fall_ff, fall_in;
   logic [31:0] cnt_ff [CHANNELS];
   logic [31:0] cnt_in [CHANNELS];
   logic        valid_ff, valid_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  hit;
   logic [31:0] sel_cnt;

   assign pop           = q_valid && (!valid_ff || rsp_ready);
   assign rsp_valid     = valid_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_status    = status_ff;

   assign hit     = ((q_op.data & ~levels_ff & rise_ff) |
                     (~q_op.data & levels_ff & fall_ff)) & CHAN_MASK;
   assign sel_cnt = cnt_ff[q_op.chan];

   always_comb begin
      levels_in = levels_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         cnt_in[k] = cnt_ff[k];
      end
      valid_in  = valid_ff && !rsp_ready;
      rdata_in  = rdata_ff;
      status_in = status_ff;
      if (pop) begin
         valid_in  = 1'b1;
         rdata_in  = 8'd0;
         status_in = STAT_OK;
         unique case (q_op.kind)
            OP_SAMPLE: begin
               levels_in = q_op.data;
               for (int k = 0; k < CHANNELS; k++) begin
                  if (hit[k]) begin
                     cnt_in[k] = cnt_ff[k] + 32'd1;
                  end
               end
            end
            OP_RD_LEVELS: rdata_in = levels_ff;
            OP_RD_RISE:   rdata_in = rise_ff;
            OP_RD_FALL:   rdata_in = fall_ff;
            OP_RD_COUNT:  rdata_in = sel_cnt[8*q_op.byte_sel +: 8];
            OP_WR_RISE:   rise_in = q_op.data;
            OP_WR_FALL:   fall_in = q_op.data;
            OP_CLEAR:     cnt_in[q_op.chan] = 32'd0;
            OP_BAD_CHAN:  status_in = STAT_BAD_CHAN;
            default:      status_in = STAT_BAD_ADDR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= 8'd0;
         rise_ff   <= 8'd0;
         fall_ff   <= 8'd0;
         for (int k = 0; k < CHANNELS; k++) begin
            cnt_ff[k] <= 32'd0;
         end
         valid_ff  <= 1'b0;
      end else begin
         levels_ff <= levels_in;
         rise_ff   <= rise_in;
         fall_ff   <= fall_in;
         for (int k = 0; k < CHANNELS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= rdata_in;
      status_ff <= status_in;
   end

endmodule

// ===== design/edge_counting_input_port.sv =====
// Each request passes through the queue and then the response register, and its response
// transfers once rsp_ready is high.
// One request per clock while responses are taken, since the execution unit updates
// the levels, masks and all edge counters at once.
// A two-entry queue sits between decoder and execution unit, and a response register
// lets a new request be taken while an older response still waits.
// Synchronous reset clears the levels, masks, counters, queue and response valid flag.
module edge_counting_input_port
   import eci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_input_levels,
   input  logic [5:0] req_register_address,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_status
);

   // Decoded operation entering the queue and the one at its head.
   op_type     dec_op;
   op_type     head_op;
   logic       push;
   logic       pop;
   logic       head_valid;
   q_stat_type q_stat;

   // The decoder classifies every command and address in the request cycle, so the
   // execution unit only ever sees a small set of operation kinds.
   eci_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_input_levels     (req_input_levels),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .q_stat               (q_stat),
      .push                 (push),
      .op                   (dec_op)
   );

   // While the response side stalls, the queue takes transfers until it is full.
   eci_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (dec_op),
      .pop     (pop),
      .q_valid (head_valid),
      .q_op    (head_op),
      .q_stat  (q_stat)
   );

   // Operations are carried out strictly in order, one per clock, whenever the
   // response register is empty or being emptied.
   eci_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (head_valid),
      .q_op          (head_op),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status)
   );

   // A flagged access always returns a zero data byte.
   a_flag_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> rsp_read_data == 8'd0)
      else $error("flagged response carries non-zero data");

   // An accepted request is still held in the queue on the following edge.
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_stat.count != '0)
      else $error("accepted request lost from the queue");

   // An operation issued to the execution unit yields a response on the next edge.
   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("issued operation produced no response");

   // The decoder never sees a free slot while the queue is full.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_ready)
      else $error("request taken while queue full");

endmodule

// ===== sim/edge_counting_input_port_tb.sv =====
// Self-checking testbench for the edge counting input port: random and directed bus traffic.
`timescale 1ns / 100ps

module edge_counting_input_port_tb;
   import eci_pkg::*;

   // Command code 3 is not defined by the port. It must be refused with a bad address status.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // The first address past the last counter byte, and the top of the address range.
   localparam logic [5:0] ADDR_PAST_COUNTS = 6'(ADDR_COUNT_BASE + 4 * CHANNELS);
   localparam logic [5:0] ADDR_TOP = 6'h3F;

   localparam int RANDOM_ITEMS = 2000;
   // The slowest legal run is about 2000 transfers, each of them held up by a sender gap and
   // a receiver stall, plus one long hold. This limit is several times that.
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
   } port_reply_type;

   // Keeps its own copy of the latched levels, the edge masks and the counters. It works out
   // the reply to every request transfer and checks the replies in order.
   class edge_count_tracker;
      logic [7:0]     level_latch;
      logic [7:0]     rise_mask;
      logic [7:0]     fall_mask;
      logic [31:0]    edge_count[CHANNELS];
      port_reply_type replies_due[$];
      int unsigned    mismatches;

      function new();
         level_latch = '0;
         rise_mask = '0;
         fall_mask = '0;
         foreach (edge_count[k]) edge_count[k] = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] levels, logic [5:0] addr,
                                 logic [7:0] wdata);
         port_reply_type reply;
         logic [7:0]     now;
         logic [7:0]     hit;
         logic [5:0]     offset;
         int             chan;
         reply.read_data = '0;
         reply.status = STAT_OK;
         case (cmd)
            CMD_SAMPLE: begin
               now = levels & CHAN_MASK;
               hit = ((now & ~level_latch & rise_mask) | (~now & level_latch & fall_mask))
                     & CHAN_MASK;
               for (int k = 0; k < CHANNELS; k++) begin
                  if (hit[k]) edge_count[k] = edge_count[k] + 32'd1;
               end
               level_latch = now;
            end
            CMD_READ: begin
               if (addr == ADDR_LEVELS) begin
                  reply.read_data = level_latch;
               end else if (addr == ADDR_RISE) begin
                  reply.read_data = rise_mask;
               end else if (addr == ADDR_FALL) begin
                  reply.read_data = fall_mask;
               end else if (addr < ADDR_COUNT_BASE) begin
                  reply.status = STAT_BAD_ADDR;
               end else begin
                  offset = addr - ADDR_COUNT_BASE;
                  chan = int'(offset[5:2]);
                  if (chan >= CHANNELS) begin
                     reply.status = STAT_BAD_ADDR;
                  end else begin
                     reply.read_data = 8'(edge_count[chan] >> {offset[1:0], 3'b000});
                  end
               end
            end
            CMD_WRITE: begin
               if (addr == ADDR_RISE) begin
                  rise_mask = wdata & CHAN_MASK;
               end else if (addr == ADDR_FALL) begin
                  fall_mask = wdata & CHAN_MASK;
               end else if (addr == ADDR_RESET) begin
                  if (wdata >= 8'd1 && int'(wdata) <= CHANNELS) begin
                     edge_count[int'(wdata) - 1] = '0;
                  end else begin
                     reply.status = STAT_BAD_CHAN;
                  end
               end else begin
                  reply.status = STAT_BAD_ADDR;
               end
            end
            default: begin
               reply.status = STAT_BAD_ADDR;
            end
         endcase
         replies_due.push_back(reply);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_reply(logic [7:0] read_data, logic [1:0] status);
         port_reply_type due;
         if (replies_due.size() == 0) begin
            report($sformatf("reply (data %02h, status %0d) with nothing outstanding",
                             read_data, status));
         end else begin
            due = replies_due.pop_front();
            if (read_data !== due.read_data)
               report($sformatf("read_data %02h, expected %02h", read_data, due.read_data));
            if (status !== due.status)
               report($sformatf("status %0d, expected %0d", status, due.status));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = CMD_SAMPLE;
   logic [7:0] req_input_levels = '0;
   logic [5:0] req_register_address = '0;
   logic [7:0] req_write_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic [1:0] rsp_status;

   edge_count_tracker tracker = new();

   // Random gaps on both sides are only inserted while this is set.
   bit idle_on = 1'b1;
   int requests_sent = 0;
   int cycle_count = 0;

   edge_counting_input_port uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_input_levels     (req_input_levels),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_status           (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one request and returns at the clock edge where its transfer takes place.
   // All outputs are read straight after the edge, so they still hold the values that the
   // block showed during the cycle before it. A gap lowers valid for a few cycles first;
   // without one, valid simply stays high from the previous transfer.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] levels,
                            input logic [5:0] addr, input logic [7:0] wdata);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_input_levels <= levels;
      req_register_address <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(cmd, levels, addr, wdata);
      requests_sent++;
   endtask

   // Builds one random request. Samples dominate, as they would in use, so that the counters
   // climb far enough for their upper bytes to change. Bus traffic mostly aims at real
   // registers, with some addresses picked from the whole range to hit the refused ones.
   task automatic send_random_item();
      int         pick;
      logic [1:0] cmd;
      logic [7:0] levels;
      logic [5:0] addr;
      logic [7:0] wdata;
      pick = $urandom_range(0, 99);
      levels = 8'($urandom_range(0, 255));
      addr = 6'($urandom_range(0, 63));
      wdata = 8'($urandom_range(0, 255));
      if (pick < 55) begin
         cmd = CMD_SAMPLE;
      end else if (pick < 75) begin
         cmd = CMD_READ;
         if ($urandom_range(0, 4) != 0) addr = 6'($urandom_range(0, int'(ADDR_PAST_COUNTS) - 1));
      end else if (pick < 94) begin
         cmd = CMD_WRITE;
         case ($urandom_range(0, 3))
            0: addr = ADDR_RISE;
            1: addr = ADDR_FALL;
            2: begin
               addr = ADDR_RESET;
               if ($urandom_range(0, 2) != 0) wdata = 8'($urandom_range(1, CHANNELS));
            end
            default: ;
         endcase
      end else begin
         cmd = CMD_UNUSED;
      end
      send_item(cmd, levels, addr, wdata);
   endtask

   // Reply side. It stalls in random bursts and, once some traffic has gone through, holds
   // off for one long stretch so that the internal queue fills and the request side stalls.
   initial begin : reply_sink
      int stall_left;
      bit long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) tracker.check_reply(rsp_read_data, rsp_status);
         if (!long_hold_done && requests_sent >= 400) begin
            stall_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Guards against a hung handshake.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A full swing of all inputs with only rising edges enabled, then with
      // falling edges enabled as well, followed by reads of every kind of register.
      send_item(CMD_WRITE, 8'h00, ADDR_RISE, 8'hFF);
      send_item(CMD_SAMPLE, 8'h00, 6'd0, 8'h00);
      send_item(CMD_SAMPLE, 8'hFF, 6'd0, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_COUNT_BASE, 8'h00);
      send_item(CMD_WRITE, 8'h00, ADDR_FALL, 8'hFF);
      send_item(CMD_SAMPLE, 8'h00, ADDR_TOP, 8'hFF);
      send_item(CMD_SAMPLE, 8'hA5, 6'd0, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_LEVELS, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_RISE, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_FALL, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_PAST_COUNTS - 6'd4, 8'h00);
      // The clear register cannot be read, and the levels and counters cannot be written.
      send_item(CMD_READ, 8'h00, ADDR_RESET, 8'h00);
      send_item(CMD_WRITE, 8'h00, ADDR_LEVELS, 8'h5A);
      send_item(CMD_WRITE, 8'h00, ADDR_COUNT_BASE, 8'hFF);
      // Addresses past the last counter byte are refused, right up to the top of the range.
      send_item(CMD_READ, 8'h00, ADDR_PAST_COUNTS, 8'h00);
      send_item(CMD_READ, 8'h00, ADDR_TOP, 8'h00);
      send_item(CMD_WRITE, 8'h00, ADDR_TOP, 8'hFF);
      // Counter clears with channel numbers either side of the legal range, then both ends.
      send_item(CMD_WRITE, 8'h00, ADDR_RESET, 8'd0);
      send_item(CMD_WRITE, 8'h00, ADDR_RESET, 8'(CHANNELS + 1));
      send_item(CMD_WRITE, 8'h00, ADDR_RESET, 8'hFF);
      send_item(CMD_WRITE, 8'h00, ADDR_RESET, 8'd1);
      send_item(CMD_WRITE, 8'h00, ADDR_RESET, 8'(CHANNELS));
      send_item(CMD_READ, 8'h00, ADDR_COUNT_BASE, 8'h00);
      // The undefined command must change nothing, whatever the other fields carry.
      send_item(CMD_UNUSED, 8'hFF, ADDR_RISE, 8'hFF);
      send_item(CMD_WRITE, 8'h00, ADDR_RISE, 8'h00);
      send_item(CMD_SAMPLE, 8'h5A, 6'd0, 8'h00);

      // Random part. Idling runs in phases, and the final stretch has none at all so that
      // the block is also seen at its full rate.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on = (i < RANDOM_ITEMS - 300) && ((i / 250) % 3 != 2);
         send_random_item();
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      // Waiting a further DRAIN_CYCLES catches any reply that turns up with nothing left outstanding.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/eci_pkg.sv
design/eci_front.sv
design/eci_queue.sv
design/eci_back.sv
design/edge_counting_input_port.sv
sim/edge_counting_input_port_tb.sv
